@@ rtl/kprc_pkg.sv @@
`default_nettype none
package kprc_pkg;

  localparam int unsigned NUM_KEYS = 6;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned NUM_REP  = 2;

  localparam int unsigned BTN_UP  = 0;
  localparam int unsigned BTN_DN  = 1;
  localparam int unsigned BTN_LT  = 2;
  localparam int unsigned BTN_RT  = 3;
  localparam int unsigned BTN_SEL = 4;

  typedef enum logic [CFG_AW-1:0] {
    CFG_DEBOUNCE    = 3'd0,
    CFG_REP_START   = 3'd1,
    CFG_REP_SLOW    = 3'd2,
    CFG_REP_FAST_AT = 3'd3,
    CFG_REP_FAST    = 3'd4,
    CFG_SETUP_HOLD  = 3'd5,
    CFG_RESET_HOLD  = 3'd6,
    CFG_UNLOCK_HOLD = 3'd7
  } cfg_idx_t;

  localparam logic [CFG_W-1:0] DEF_DEBOUNCE    = 16'd30;
  localparam logic [CFG_W-1:0] DEF_REP_START   = 16'd600;
  localparam logic [CFG_W-1:0] DEF_REP_SLOW    = 16'd180;
  localparam logic [CFG_W-1:0] DEF_REP_FAST_AT = 16'd2000;
  localparam logic [CFG_W-1:0] DEF_REP_FAST    = 16'd80;
  localparam logic [CFG_W-1:0] DEF_SETUP_HOLD  = 16'd1500;
  localparam logic [CFG_W-1:0] DEF_RESET_HOLD  = 16'd5000;
  localparam logic [CFG_W-1:0] DEF_UNLOCK_HOLD = 16'd5000;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] repeat_start_ms;
    logic [CFG_W-1:0] repeat_slow_ms;
    logic [CFG_W-1:0] repeat_fast_after_ms;
    logic [CFG_W-1:0] repeat_fast_ms;
    logic [CFG_W-1:0] setup_hold_ms;
    logic [CFG_W-1:0] reset_hold_ms;
    logic [CFG_W-1:0] unlock_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic                menu_idle;
    logic                fault_latched;
    logic                battery_warning;
    logic                safe_mode;
    logic [NUM_REP-1:0]  repeat_allowed;
  } flags_t;

  typedef struct packed {
    logic [NUM_KEYS-1:0] events;
    logic                fault_ack;
    logic                battery_ack;
    logic [NUM_KEYS-1:0] stable;
  } key_res_t;

endpackage
`default_nettype wire

@@ rtl/kprc_keys.sv @@
`default_nettype none
module kprc_keys #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic [kprc_pkg::NUM_KEYS-1:0] raw,
  input  wire logic [TIME_BITS-1:0]          now,
  input  wire kprc_pkg::flags_t              flags,
  input  wire kprc_pkg::cfg_t                cfg,
  output kprc_pkg::key_res_t                 res
);

  localparam int unsigned NK = kprc_pkg::NUM_KEYS;
  localparam int unsigned NR = kprc_pkg::NUM_REP;

  logic [NK-1:0]        deb_r, deb_nxt;
  logic [NK-1:0]        last_r, last_nxt;
  logic [NK-1:0]        pv_r, pv_nxt;
  logic [TIME_BITS-1:0] rct_r [NK];
  logic [TIME_BITS-1:0] rct_nxt [NK];
  logic [TIME_BITS-1:0] pt_r [NK];
  logic [TIME_BITS-1:0] pt_nxt [NK];
  logic [TIME_BITS-1:0] lrt_r [NR];
  logic [TIME_BITS-1:0] lrt_nxt [NR];
  logic [NR-1:0]        rv_r, rv_nxt;

  logic [NK-1:0]        flip;
  logic [NK-1:0]        ev;
  logic                 fack;
  logic                 back;
  logic                 raw_ud;
  logic [TIME_BITS-1:0] deb_ms;
  logic [TIME_BITS-1:0] start_ms;
  logic [TIME_BITS-1:0] slow_ms;
  logic [TIME_BITS-1:0] fast_at_ms;
  logic [TIME_BITS-1:0] fast_ms;

  assign deb_ms     = TIME_BITS'(cfg.debounce_ms);
  assign start_ms   = TIME_BITS'(cfg.repeat_start_ms);
  assign slow_ms    = TIME_BITS'(cfg.repeat_slow_ms);
  assign fast_at_ms = TIME_BITS'(cfg.repeat_fast_after_ms);
  assign fast_ms    = TIME_BITS'(cfg.repeat_fast_ms);
  assign raw_ud     = raw[kprc_pkg::BTN_UP] & raw[kprc_pkg::BTN_DN];

  always_comb begin
    logic                 dbk_en;
    logic [TIME_BITS-1:0] held;
    logic [TIME_BITS-1:0] interval;
    deb_nxt  = deb_r;
    last_nxt = last_r;
    pv_nxt   = pv_r;
    rct_nxt  = rct_r;
    pt_nxt   = pt_r;
    lrt_nxt  = lrt_r;
    rv_nxt   = rv_r;
    flip     = '0;
    ev       = '0;
    fack     = 1'b0;
    back     = 1'b0;
    held     = '0;
    interval = '0;
    dbk_en   = 1'b0;
    for (int k = 0; k < NK; k++) begin
      dbk_en = !flags.safe_mode || (k == kprc_pkg::BTN_SEL);
      if (dbk_en) begin
        if (raw[k] != last_r[k]) begin
          last_nxt[k] = raw[k];
          rct_nxt[k]  = now;
        end
        if ((raw[k] != deb_r[k]) && ((now - rct_nxt[k]) >= deb_ms)) begin
          deb_nxt[k] = raw[k];
          flip[k]    = 1'b1;
        end
      end
      if (!flags.safe_mode && flip[k]) begin
        if (deb_nxt[k]) begin
          pt_nxt[k] = now;
          pv_nxt[k] = 1'b1;
          if (k < NR) begin
            rv_nxt[k] = 1'b0;
          end
          if (!((k < NR) && raw_ud)) begin
            if ((k == kprc_pkg::BTN_SEL) && flags.fault_latched) begin
              fack = 1'b1;
            end else if ((k == kprc_pkg::BTN_SEL) && flags.battery_warning) begin
              back = 1'b1;
            end else begin
              ev[k] = 1'b1;
            end
          end
        end else begin
          pv_nxt[k] = 1'b0;
          if (k < NR) begin
            rv_nxt[k] = 1'b0;
          end
        end
      end
    end
    for (int k = 0; k < NR; k++) begin
      held     = now - pt_nxt[k];
      interval = (held >= fast_at_ms) ? fast_ms : slow_ms;
      if (!flags.safe_mode && flags.repeat_allowed[k] && !raw_ud && deb_nxt[k] && pv_nxt[k]
          && (held >= start_ms)
          && !(rv_nxt[k] && ((now - lrt_nxt[k]) < interval))) begin
        lrt_nxt[k] = now;
        rv_nxt[k]  = 1'b1;
        ev[k]      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r  <= '0;
      last_r <= '0;
      pv_r   <= '0;
      rv_r   <= '0;
      for (int k = 0; k < NK; k++) begin
        rct_r[k] <= '0;
        pt_r[k]  <= '0;
      end
      for (int k = 0; k < NR; k++) begin
        lrt_r[k] <= '0;
      end
    end else if (en) begin
      deb_r  <= deb_nxt;
      last_r <= last_nxt;
      pv_r   <= pv_nxt;
      rv_r   <= rv_nxt;
      rct_r  <= rct_nxt;
      pt_r   <= pt_nxt;
      lrt_r  <= lrt_nxt;
    end
  end

  assign res = '{events: ev, fault_ack: fack, battery_ack: back, stable: deb_nxt};

endmodule
`default_nettype wire

@@ rtl/kprc_combo.sv @@
`default_nettype none
module kprc_combo #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         held,
  input  wire logic [TIME_BITS-1:0]         now,
  input  wire logic [kprc_pkg::CFG_W-1:0]   hold_ms,
  output logic                              fire
);

  logic                 active_r, active_nxt;
  logic                 done_r, done_nxt;
  logic [TIME_BITS-1:0] start_r, start_nxt;
  logic                 elapsed;

  assign elapsed = (now - start_r) >= TIME_BITS'(hold_ms);
  assign fire    = en && held && active_r && !done_r && elapsed;

  always_comb begin
    active_nxt = active_r;
    done_nxt   = done_r;
    start_nxt  = start_r;
    if (!held) begin
      active_nxt = 1'b0;
      done_nxt   = 1'b0;
    end else if (!active_r) begin
      active_nxt = 1'b1;
      done_nxt   = 1'b0;
      start_nxt  = now;
    end else if (elapsed) begin
      done_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      start_r  <= '0;
    end else if (en) begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
      start_r  <= start_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/keypad_repeat_combo_detector_top.sv @@
`default_nettype none
// Keypad debounce, auto-repeat and long-press combination detector.
// Each transaction passes an input register, then a result register; per-key work is
// one combinational pass. One transaction per cycle unless out_ready stalls the output.
// Reset (rst_n low, synchronous): key state, combo state and both stages cleared,
// configuration registers return to their default values.
module keypad_repeat_combo_detector_top #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [5:0]                     in_raw_keys,
  input  wire logic [31:0]                    in_now_ms,
  input  wire logic [1:0]                     in_repeat_allowed,
  input  wire logic                           in_menu_idle,
  input  wire logic                           in_fault_latched,
  input  wire logic                           in_battery_warning,
  input  wire logic                           in_safe_mode,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [5:0]                          out_menu_key_events,
  output logic                                out_fault_ack,
  output logic                                out_battery_ack,
  output logic                                out_setup_request,
  output logic                                out_reset_request,
  output logic                                out_unlock_request,
  output logic [5:0]                          out_stable_keys,
  input  wire logic                           cfg_we,
  input  wire logic [kprc_pkg::CFG_AW-1:0]    cfg_addr,
  input  wire logic [kprc_pkg::CFG_W-1:0]     cfg_wdata
);

  kprc_pkg::cfg_t                    cfg_r;
  logic                              s1_valid_r;
  logic [kprc_pkg::NUM_KEYS-1:0]     s1_raw_r;
  logic [TIME_BITS-1:0]              s1_now_r;
  kprc_pkg::flags_t                  s1_flags_r;
  logic                              s1_adv;
  logic                              out_valid_r;
  kprc_pkg::key_res_t                out_res_r;
  logic                              out_setup_r;
  logic                              out_reset_r;
  logic                              out_unlock_r;
  kprc_pkg::key_res_t                key_res;
  logic                              setup_fire;
  logic                              reset_fire;
  logic                              unlock_fire;
  logic                              norm_en;
  logic                              safe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms          <= kprc_pkg::DEF_DEBOUNCE;
      cfg_r.repeat_start_ms      <= kprc_pkg::DEF_REP_START;
      cfg_r.repeat_slow_ms       <= kprc_pkg::DEF_REP_SLOW;
      cfg_r.repeat_fast_after_ms <= kprc_pkg::DEF_REP_FAST_AT;
      cfg_r.repeat_fast_ms       <= kprc_pkg::DEF_REP_FAST;
      cfg_r.setup_hold_ms        <= kprc_pkg::DEF_SETUP_HOLD;
      cfg_r.reset_hold_ms        <= kprc_pkg::DEF_RESET_HOLD;
      cfg_r.unlock_hold_ms       <= kprc_pkg::DEF_UNLOCK_HOLD;
    end else if (cfg_we) begin
      case (kprc_pkg::cfg_idx_t'(cfg_addr))
        kprc_pkg::CFG_DEBOUNCE:    cfg_r.debounce_ms          <= cfg_wdata;
        kprc_pkg::CFG_REP_START:   cfg_r.repeat_start_ms      <= cfg_wdata;
        kprc_pkg::CFG_REP_SLOW:    cfg_r.repeat_slow_ms       <= cfg_wdata;
        kprc_pkg::CFG_REP_FAST_AT: cfg_r.repeat_fast_after_ms <= cfg_wdata;
        kprc_pkg::CFG_REP_FAST:    cfg_r.repeat_fast_ms       <= cfg_wdata;
        kprc_pkg::CFG_SETUP_HOLD:  cfg_r.setup_hold_ms        <= cfg_wdata;
        kprc_pkg::CFG_RESET_HOLD:  cfg_r.reset_hold_ms        <= cfg_wdata;
        kprc_pkg::CFG_UNLOCK_HOLD: cfg_r.unlock_hold_ms       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // advance stage 1 into the result register when it is empty or being drained
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_raw_r                   <= in_raw_keys;
      s1_now_r                   <= in_now_ms[TIME_BITS-1:0];
      s1_flags_r.menu_idle       <= in_menu_idle;
      s1_flags_r.fault_latched   <= in_fault_latched;
      s1_flags_r.battery_warning <= in_battery_warning;
      s1_flags_r.safe_mode       <= in_safe_mode;
      s1_flags_r.repeat_allowed  <= in_repeat_allowed;
    end
  end

  assign norm_en = s1_adv && !s1_flags_r.safe_mode;
  assign safe_en = s1_adv && s1_flags_r.safe_mode;

  kprc_keys #(.TIME_BITS(TIME_BITS)) u_keys (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (s1_adv),
    .raw   (s1_raw_r),
    .now   (s1_now_r),
    .flags (s1_flags_r),
    .cfg   (cfg_r),
    .res   (key_res)
  );

  kprc_combo #(.TIME_BITS(TIME_BITS)) u_setup (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (norm_en),
    .held    (s1_flags_r.menu_idle && key_res.stable[kprc_pkg::BTN_LT]
              && key_res.stable[kprc_pkg::BTN_RT]),
    .now     (s1_now_r),
    .hold_ms (cfg_r.setup_hold_ms),
    .fire    (setup_fire)
  );

  kprc_combo #(.TIME_BITS(TIME_BITS)) u_reset (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (norm_en),
    .held    (key_res.stable[kprc_pkg::BTN_UP] && key_res.stable[kprc_pkg::BTN_DN]),
    .now     (s1_now_r),
    .hold_ms (cfg_r.reset_hold_ms),
    .fire    (reset_fire)
  );

  kprc_combo #(.TIME_BITS(TIME_BITS)) u_unlock (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (safe_en),
    .held    (key_res.stable[kprc_pkg::BTN_SEL]),
    .now     (s1_now_r),
    .hold_ms (cfg_r.unlock_hold_ms),
    .fire    (unlock_fire)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r    <= key_res;
      out_setup_r  <= setup_fire;
      out_reset_r  <= reset_fire;
      out_unlock_r <= unlock_fire;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_menu_key_events = out_res_r.events;
  assign out_fault_ack       = out_res_r.fault_ack;
  assign out_battery_ack     = out_res_r.battery_ack;
  assign out_setup_request   = out_setup_r;
  assign out_reset_request   = out_reset_r;
  assign out_unlock_request  = out_unlock_r;
  assign out_stable_keys     = out_res_r.stable;

`ifndef SYNTHESIS
  a_ack_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_fault_ack && out_battery_ack))
    else $error("fault and battery acknowledged together");

  a_sel_event_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_menu_key_events[kprc_pkg::BTN_SEL]
                      && (out_fault_ack || out_battery_ack)))
    else $error("select event issued alongside an acknowledge");

  a_mode_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_unlock_request && (out_setup_request || out_reset_request)))
    else $error("safe-mode unlock mixed with normal-mode requests");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced transaction missing from result register");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_now_r)))
    else $error("stalled stage 1 transaction lost");
`endif

endmodule
`default_nettype wire
